@@ rtl/json_string_unescape_utf8_assert.svh @@
// Assertion macros shared by the JSON string unescape RTL.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam int CP_W        = 21;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_DONE   = 3'd1,
        KIND_CTRL   = 3'd2,
        KIND_BADESC = 3'd3,
        KIND_BADUNI = 3'd4,
        KIND_UNTESC = 3'd5,
        KIND_UNTSTR = 3'd6
    } kind_t;

    // One request from the decoder to the serializer: a code point with its
    // UTF-8 length minus one, or a single status result.
    typedef struct packed {
        kind_t             kind;
        logic [CP_W-1:0]   cp;
        logic [1:0]        nm1;
    } rec_t;

endpackage

`default_nettype wire

@@ rtl/jsu_fifo.sv @@
// ----------------------------------------------------------------------------
// jsu_fifo
// Short request queue between the decoder front and the UTF-8 back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_utf8_assert.svh"

module jsu_fifo #(
    parameter int Depth = jsu_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire jsu_pkg::rec_t wr_data,
    output logic              full,
    input  wire logic         rd_en,
    output jsu_pkg::rec_t     rd_data,
    output logic              empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    jsu_pkg::rec_t   mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `JSU_ASSERT_NOW(a_no_overflow, clk, rst_n, wr_en, !full || rd_en, "queue overflow")
    `JSU_ASSERT_NOW(a_no_underflow, clk, rst_n, rd_en, !empty, "queue underflow")
    `JSU_ASSERT_NEXT(a_count_step, clk, rst_n, wr_en && !rd_en,
                     count_reg == $past(count_reg) + 1'b1, "queue count did not grow")

endmodule

`default_nettype wire

@@ rtl/jsu_front.sv @@
// ----------------------------------------------------------------------------
// jsu_front
// Decoder front end: tracks the escape state and turns each accepted byte
// into at most one request for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   in_byte,
    input  wire logic         end_of_text,
    output logic              rec_valid,
    output jsu_pkg::rec_t     rec
);

    typedef enum logic [2:0] {
        MODE_BODY = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_HEX1 = 3'd2,
        MODE_BSL  = 3'd3,
        MODE_U    = 3'd4,
        MODE_HEX2 = 3'd5
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [11:0] accum_reg, accum_next;
    logic [9:0]  high_reg, high_next;

    logic        is_hex;
    logic [3:0]  hex_val;
    logic [15:0] unit;
    logic [jsu_pkg::CP_W-1:0] pair_cp;
    logic        esc_ok;
    logic [7:0]  esc_byte;

    function automatic logic [1:0] utf8_nm1(input logic [jsu_pkg::CP_W-1:0] cp);
        logic [1:0] n;
        if (cp <= 21'h7f)
        begin
            n = 2'd0;
        end
        else if (cp <= 21'h7ff)
        begin
            n = 2'd1;
        end
        else if (cp <= 21'hffff)
        begin
            n = 2'd2;
        end
        else
        begin
            n = 2'd3;
        end
        return n;
    endfunction

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= "0" && in_byte <= "9")
        begin
            hex_val = 4'(in_byte - "0");
        end
        else if (in_byte >= "a" && in_byte <= "f")
        begin
            hex_val = 4'(in_byte - "a" + 8'd10);
        end
        else if (in_byte >= "A" && in_byte <= "F")
        begin
            hex_val = 4'(in_byte - "A" + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        esc_ok   = 1'b1;
        esc_byte = 8'h00;
        case (in_byte)
            8'h22:   esc_byte = 8'h22;
            8'h5c:   esc_byte = 8'h5c;
            8'h2f:   esc_byte = 8'h2f;
            8'h62:   esc_byte = 8'h08;
            8'h66:   esc_byte = 8'h0c;
            8'h6e:   esc_byte = 8'h0a;
            8'h72:   esc_byte = 8'h0d;
            8'h74:   esc_byte = 8'h09;
            default: esc_ok   = 1'b0;
        endcase
    end

    assign unit    = {accum_reg, hex_val};
    assign pair_cp = {1'b0, high_reg, unit[9:0]} + 21'h10000;

    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        accum_next   = accum_reg;
        high_next    = high_reg;
        rec_valid    = 1'b0;
        rec.kind     = jsu_pkg::KIND_DATA;
        rec.cp       = '0;
        rec.nm1      = 2'd0;

        case (mode_reg)
            MODE_ESC:
            begin
                if (end_of_text)
                begin
                    rec_valid = 1'b1;
                    rec.kind  = jsu_pkg::KIND_UNTESC;
                    mode_next = MODE_BODY;
                end
                else if (in_byte == "u")
                begin
                    mode_next    = MODE_HEX1;
                    hex_cnt_next = 2'd0;
                    accum_next   = '0;
                end
                else if (!esc_ok)
                begin
                    rec_valid = 1'b1;
                    rec.kind  = jsu_pkg::KIND_BADESC;
                    mode_next = MODE_BODY;
                end
                else
                begin
                    rec_valid = 1'b1;
                    rec.cp    = {13'd0, esc_byte};
                    mode_next = MODE_BODY;
                end
            end

            MODE_HEX1, MODE_HEX2:
            begin
                if (end_of_text || !is_hex)
                begin
                    rec_valid = 1'b1;
                    rec.kind  = jsu_pkg::KIND_BADUNI;
                end
                else if (hex_cnt_reg != 2'd3)
                begin
                    accum_next   = unit[11:0];
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end
                else if (mode_reg == MODE_HEX1)
                begin
                    if (unit[15:10] == 6'b110110)
                    begin
                        high_next = unit[9:0];
                        mode_next = MODE_BSL;
                    end
                    else if (unit[15:10] == 6'b110111)
                    begin
                        rec_valid = 1'b1;
                        rec.kind  = jsu_pkg::KIND_BADUNI;
                    end
                    else
                    begin
                        rec_valid = 1'b1;
                        rec.cp    = {5'd0, unit};
                        rec.nm1   = utf8_nm1({5'd0, unit});
                        mode_next = MODE_BODY;
                    end
                end
                else if (unit[15:10] != 6'b110111)
                begin
                    rec_valid = 1'b1;
                    rec.kind  = jsu_pkg::KIND_BADUNI;
                end
                else
                begin
                    rec_valid = 1'b1;
                    rec.cp    = pair_cp;
                    rec.nm1   = utf8_nm1(pair_cp);
                    mode_next = MODE_BODY;
                end
                if (!(is_hex && !end_of_text && hex_cnt_reg != 2'd3))
                begin
                    hex_cnt_next = 2'd0;
                    accum_next   = '0;
                end
            end

            MODE_BSL:
            begin
                if (end_of_text || in_byte != "\\")
                begin
                    rec_valid = 1'b1;
                    rec.kind  = jsu_pkg::KIND_BADUNI;
                end
                else
                begin
                    mode_next = MODE_U;
                end
            end

            MODE_U:
            begin
                if (end_of_text || in_byte != "u")
                begin
                    rec_valid = 1'b1;
                    rec.kind  = jsu_pkg::KIND_BADUNI;
                end
                else
                begin
                    mode_next    = MODE_HEX2;
                    hex_cnt_next = 2'd0;
                    accum_next   = '0;
                end
            end

            default:
            begin
                mode_next = MODE_BODY;
                if (end_of_text)
                begin
                    rec_valid = 1'b1;
                    rec.kind  = jsu_pkg::KIND_UNTSTR;
                end
                else if (in_byte == "\"")
                begin
                    rec_valid = 1'b1;
                    rec.kind  = jsu_pkg::KIND_DONE;
                end
                else if (in_byte < 8'h20)
                begin
                    rec_valid = 1'b1;
                    rec.kind  = jsu_pkg::KIND_CTRL;
                end
                else if (in_byte == "\\")
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    rec_valid = 1'b1;
                    rec.cp    = {13'd0, in_byte};
                end
            end
        endcase

        // Any status result returns the decoder to its reset state.
        if (rec_valid && rec.kind != jsu_pkg::KIND_DATA)
        begin
            mode_next    = MODE_BODY;
            hex_cnt_next = 2'd0;
            accum_next   = '0;
            high_next    = '0;
        end
        else if (rec_valid && (mode_reg == MODE_HEX2))
        begin
            high_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_BODY;
            hex_cnt_reg <= 2'd0;
            accum_reg   <= '0;
            high_reg    <= '0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            accum_reg   <= accum_next;
            high_reg    <= high_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/jsu_back.sv @@
// ----------------------------------------------------------------------------
// jsu_back
// UTF-8 back end: takes one request from the queue and hands out its bytes
// one result at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_utf8_assert.svh"

module jsu_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire jsu_pkg::rec_t q_data,
    input  wire logic         q_empty,
    output logic              q_rd,
    output logic [7:0]        out_byte,
    output logic [2:0]        result_kind,
    output logic              last_of_run,
    output logic              empty,
    input  wire logic         pop
);

    jsu_pkg::rec_t cur_reg;
    logic          valid_reg;
    logic [1:0]    idx_reg;
    logic          take;
    logic          load;

    function automatic logic [7:0] utf8_byte(input logic [jsu_pkg::CP_W-1:0] cp,
                                             input logic [1:0] nm1,
                                             input logic [1:0] idx);
        logic [1:0] pos;
        logic [5:0] six;
        logic [7:0] b;
        pos = nm1 - idx;
        case (pos)
            2'd0:    six = cp[5:0];
            2'd1:    six = cp[11:6];
            2'd2:    six = cp[17:12];
            default: six = {3'd0, cp[20:18]};
        endcase
        if (nm1 == 2'd0)
        begin
            b = cp[7:0];
        end
        else if (idx != 2'd0)
        begin
            b = {2'b10, six};
        end
        else
        begin
            case (nm1)
                2'd1:    b = {3'b110, cp[10:6]};
                2'd2:    b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
        end
        return b;
    endfunction

    assign empty       = !valid_reg;
    assign last_of_run = (idx_reg == cur_reg.nm1);
    assign result_kind = cur_reg.kind;
    assign out_byte    = utf8_byte(cur_reg.cp, cur_reg.nm1, idx_reg);

    assign take = pop && valid_reg;
    assign load = !valid_reg || (take && last_of_run);
    assign q_rd = load && !q_empty;

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= !q_empty;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    `JSU_ASSERT_NOW(a_status_single, clk, rst_n,
                    valid_reg && (cur_reg.kind != jsu_pkg::KIND_DATA),
                    cur_reg.nm1 == 2'd0 && idx_reg == 2'd0,
                    "status result spans several bytes")
    `JSU_ASSERT_NEXT(a_run_holds, clk, rst_n, take && !last_of_run,
                     valid_reg && idx_reg == $past(idx_reg) + 2'd1,
                     "multi-byte run broken")
    `JSU_ASSERT_NOW(a_idx_bound, clk, rst_n, valid_reg, idx_reg <= cur_reg.nm1,
                    "byte index past end of sequence")

endmodule

`default_nettype wire

@@ rtl/json_string_unescape_utf8.sv @@
// A byte that yields a result writes a request into the queue; the output stage then
// loads the request from the queue and drives it onto the result ports.
// One input byte is accepted per cycle while the queue is not full; the output stage
// hands out each request's N-byte UTF-8 sequence one byte per pop.
// Reset: rst_n clears the decoder to body mode and empties the queue and output stage.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string body into UTF-8 bytes and status results.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   in_byte,
    input  wire logic         end_of_text,
    output logic              empty,
    input  wire logic         pop,
    output logic [7:0]        out_byte,
    output logic [2:0]        result_kind,
    output logic              last_of_run
);

    logic          accept;
    logic          rec_valid;
    jsu_pkg::rec_t rec;
    logic          q_full;
    logic          q_empty;
    logic          q_rd;
    jsu_pkg::rec_t q_data;

    assign full   = q_full;
    assign accept = push && !q_full;

    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    jsu_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && rec_valid),
        .wr_data (rec),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_data),
        .q_empty     (q_empty),
        .q_rd        (q_rd),
        .out_byte    (out_byte),
        .result_kind (result_kind),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

`default_nettype wire

@@ verif/json_string_unescape_utf8_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_checker
// Watches both queue interfaces of the JSON string unescape decoder, predicts
// the results of every accepted request and compares each popped result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module json_string_unescape_utf8_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic       full,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic [7:0] out_byte,
    input  wire logic [2:0] result_kind,
    input  wire logic       last_of_run,
    output int              mismatch_count,
    output int              results_outstanding
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        ST_BODY      = 3'd0,
        ST_ESC       = 3'd1,
        ST_HEX_FIRST = 3'd2,
        ST_WAIT_BSL  = 3'd3,
        ST_WAIT_U    = 3'd4,
        ST_HEX_LOW   = 3'd5
    } dec_mode_t;

    typedef struct {
        logic [7:0]     data;
        jsu_pkg::kind_t kind;
        logic           last;
    } decoded_result_t;

    dec_mode_t       dec_mode;
    logic [1:0]      digit_count;
    logic [15:0]     unit_accum;
    logic [9:0]      high_bits;
    decoded_result_t decoded_q[$];

    function automatic void clear_decoder();
        dec_mode    = ST_BODY;
        digit_count = 2'd0;
        unit_accum  = 16'h0000;
        high_bits   = 10'h000;
    endfunction

    function automatic void add_result(logic [7:0] data, jsu_pkg::kind_t kind, logic last);
        decoded_result_t r;
        r.data = data;
        r.kind = kind;
        r.last = last;
        decoded_q.push_back(r);
    endfunction

    function automatic void end_string(jsu_pkg::kind_t kind);
        add_result(8'h00, kind, 1'b1);
        clear_decoder();
    endfunction

    function automatic void add_utf8(logic [20:0] cp);
        if (cp <= 21'h7F)
        begin
            add_result(cp[7:0], jsu_pkg::KIND_DATA, 1'b1);
        end
        else if (cp <= 21'h7FF)
        begin
            add_result({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, 1'b0);
            add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, 1'b1);
        end
        else if (cp <= 21'hFFFF)
        begin
            add_result({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, 1'b0);
            add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, 1'b0);
            add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, 1'b1);
        end
        else
        begin
            add_result({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, 1'b0);
            add_result({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, 1'b0);
            add_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, 1'b0);
            add_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, 1'b1);
        end
    endfunction

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    // Bit 8 set means the letter is not a known escape.
    function automatic logic [8:0] escape_value(logic [7:0] c);
        case (c)
            CH_QUOTE: return {1'b0, CH_QUOTE};
            CH_BSL:   return {1'b0, CH_BSL};
            8'h2F:    return 9'h02F;
            8'h62:    return 9'h008;
            8'h66:    return 9'h00C;
            8'h6E:    return 9'h00A;
            8'h72:    return 9'h00D;
            8'h74:    return 9'h009;
            default:  return 9'h100;
        endcase
    endfunction

    function automatic void decode_request(logic [7:0] b, logic eot);
        logic [4:0]  d;
        logic [8:0]  esc;
        logic [15:0] v;
        case (dec_mode)
            ST_ESC:
            begin
                esc = escape_value(b);
                if (eot) end_string(jsu_pkg::KIND_UNTESC);
                else if (b == CH_U)
                begin
                    dec_mode    = ST_HEX_FIRST;
                    digit_count = 2'd0;
                    unit_accum  = 16'h0000;
                end
                else if (esc[8]) end_string(jsu_pkg::KIND_BADESC);
                else
                begin
                    dec_mode = ST_BODY;
                    add_result(esc[7:0], jsu_pkg::KIND_DATA, 1'b1);
                end
            end
            ST_HEX_FIRST, ST_HEX_LOW:
            begin
                d = hex_digit(b);
                v = {unit_accum[11:0], d[3:0]};
                if (eot || d[4]) end_string(jsu_pkg::KIND_BADUNI);
                else if (digit_count != 2'd3)
                begin
                    unit_accum  = v;
                    digit_count = digit_count + 2'd1;
                end
                else
                begin
                    digit_count = 2'd0;
                    unit_accum  = 16'h0000;
                    if (dec_mode == ST_HEX_FIRST)
                    begin
                        if (v >= 16'hD800 && v <= 16'hDBFF)
                        begin
                            high_bits = v[9:0];
                            dec_mode  = ST_WAIT_BSL;
                        end
                        else if (v >= 16'hDC00 && v <= 16'hDFFF)
                            end_string(jsu_pkg::KIND_BADUNI);
                        else
                        begin
                            dec_mode = ST_BODY;
                            add_utf8({5'd0, v});
                        end
                    end
                    else if (v < 16'hDC00 || v > 16'hDFFF) end_string(jsu_pkg::KIND_BADUNI);
                    else
                    begin
                        add_utf8(21'h10000 + {1'b0, high_bits, v[9:0]});
                        high_bits = 10'h000;
                        dec_mode  = ST_BODY;
                    end
                end
            end
            ST_WAIT_BSL:
            begin
                if (eot || b != CH_BSL) end_string(jsu_pkg::KIND_BADUNI);
                else dec_mode = ST_WAIT_U;
            end
            ST_WAIT_U:
            begin
                if (eot || b != CH_U) end_string(jsu_pkg::KIND_BADUNI);
                else
                begin
                    dec_mode    = ST_HEX_LOW;
                    digit_count = 2'd0;
                    unit_accum  = 16'h0000;
                end
            end
            default:
            begin
                dec_mode = ST_BODY;
                if (eot) end_string(jsu_pkg::KIND_UNTSTR);
                else if (b == CH_QUOTE) end_string(jsu_pkg::KIND_DONE);
                else if (b < CH_SPACE) end_string(jsu_pkg::KIND_CTRL);
                else if (b == CH_BSL) dec_mode = ST_ESC;
                else add_result(b, jsu_pkg::KIND_DATA, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s: got 0x%02h, want 0x%02h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        decoded_result_t e;
        if (decoded_q.size() == 0)
        begin
            report_mismatch("result with no request behind it", out_byte, 8'h00);
        end
        else
        begin
            e = decoded_q.pop_front();
            if (result_kind !== e.kind)
                report_mismatch("result_kind", {5'd0, result_kind}, {5'd0, e.kind});
            if (out_byte !== e.data)
                report_mismatch("out_byte", out_byte, e.data);
            if (last_of_run !== e.last)
                report_mismatch("last_of_run", {7'd0, last_of_run}, {7'd0, e.last});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_decoder();
            decoded_q.delete();
            mismatch_count      = 0;
            results_outstanding = 0;
        end
        else
        begin
            if (push && !full) decode_request(in_byte, end_of_text);
            if (pop && !empty) check_result();
            results_outstanding = decoded_q.size();
        end
    end

endmodule

@@ verif/json_string_unescape_utf8_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// Drives JSON string bodies into the unescape decoder: a short directed list
// of edge and error cases, then random strings with escapes, unicode units
// and surrogate pairs, mixed with noise and broken sequences. Both sides
// idle at random, and the reader once holds off long enough to fill the
// block. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module json_string_unescape_utf8_tb;

    localparam int         RANDOM_REQUESTS = 135;
    localparam int         DIRECTED_COUNT  = 25;
    localparam int         HOLD_CYCLES     = 80;
    localparam int         HOLD_AFTER      = 40;
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         STALL_LIMIT     = 2000;
    localparam logic [7:0] CH_QUOTE        = 8'h22;
    localparam logic [7:0] CH_BSL          = 8'h5C;
    localparam logic [7:0] CH_U            = 8'h75;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic [7:0] in_byte     = 8'h00;
    logic       end_of_text = 1'b0;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic [2:0] result_kind;
    logic       last_of_run;

    int mismatch_count;
    int results_outstanding;
    int requests_sent = 0;
    int send_burst    = 0;
    int recv_burst    = 0;
    int stall_cycles  = 0;
    bit reader_holding = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    json_string_unescape_utf8 u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .result_kind (result_kind),
        .last_of_run (last_of_run)
    );

    json_string_unescape_utf8_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .in_byte             (in_byte),
        .end_of_text         (end_of_text),
        .empty               (empty),
        .pop                 (pop),
        .out_byte            (out_byte),
        .result_kind         (result_kind),
        .last_of_run         (last_of_run),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    // Runs with no idle gap start now and then on either side.
    task automatic draw_gap(inout int burst, output int gap);
        if (burst > 0)
        begin
            burst--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 15) == 0) burst = int'($urandom_range(10, 30));
            gap = int'($urandom_range(0, 7));
        end
    endtask

    task automatic send_request(input logic [7:0] b, input logic eot);
        int gap;
        draw_gap(send_burst, gap);
        if (reader_holding) gap = 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push        <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        do @(posedge clk); while (full);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(b, 1'b0);
    endtask

    task automatic send_eot();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, logic upper);
        if (n < 4'd10) return 8'h30 + {4'd0, n};
        return (upper ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
    endfunction

    task automatic send_unit(input logic [15:0] v);
        send_byte(CH_BSL);
        send_byte(CH_U);
        for (int i = 3; i >= 0; i--)
            send_byte(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
    endtask

    task automatic send_code_point();
        logic [15:0] v;
        case ($urandom_range(0, 4))
            0: send_unit(16'($urandom_range(0, 16'h7F)));
            1: send_unit(16'($urandom_range(16'h80, 16'h7FF)));
            2:
            begin
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
                send_unit(v);
            end
            3:
            begin
                send_unit(16'hD800 | 16'($urandom_range(0, 16'h3FF)));
                send_unit(16'hDC00 | 16'($urandom_range(0, 16'h3FF)));
            end
            default:
            begin
                case ($urandom_range(0, 6))
                    0: send_unit(16'h0000);
                    1: send_unit(16'h007F);
                    2: send_unit(16'h0080);
                    3: send_unit(16'h07FF);
                    4: send_unit(16'hFFFF);
                    5:
                    begin
                        send_unit(16'hD800);
                        send_unit(16'hDC00);
                    end
                    default:
                    begin
                        send_unit(16'hDBFF);
                        send_unit(16'hDFFF);
                    end
                endcase
            end
        endcase
    endtask

    task automatic send_string();
        logic [7:0] b;
        int pieces;
        pieces = int'($urandom_range(0, 5));
        repeat (pieces)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSL);
                    send_byte(b);
                end
                4, 5:
                begin
                    send_byte(CH_BSL);
                    case ($urandom_range(0, 7))
                        0: send_byte(CH_QUOTE);
                        1: send_byte(CH_BSL);
                        2: send_byte(8'h2F);
                        3: send_byte(8'h62);
                        4: send_byte(8'h66);
                        5: send_byte(8'h6E);
                        6: send_byte(8'h72);
                        default: send_byte(8'h74);
                    endcase
                end
                default: send_code_point();
            endcase
        end
        send_byte(CH_QUOTE);
    endtask

    task automatic send_tail();
        if ($urandom_range(0, 2) == 0) send_eot();
        else send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        int digits;
        case ($urandom_range(0, 6))
            0: send_byte(8'($urandom_range(0, 255)));
            1: send_eot();
            2:
            begin
                send_byte(CH_BSL);
                send_tail();
            end
            3:
            begin
                digits = int'($urandom_range(0, 3));
                send_byte(CH_BSL);
                send_byte(CH_U);
                repeat (digits)
                    send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                send_tail();
            end
            4:
            begin
                send_unit(16'hD800 | 16'($urandom_range(0, 16'h3FF)));
                send_tail();
            end
            5:
            begin
                send_unit(16'hD800 | 16'($urandom_range(0, 16'h3FF)));
                send_byte(CH_BSL);
                send_tail();
            end
            default:
            begin
                send_unit(16'hD800 | 16'($urandom_range(0, 16'h3FF)));
                send_unit(16'($urandom_range(0, 16'hFFFF)));
            end
        endcase
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        send_byte(8'h20);
        send_byte(8'hFF);
        send_byte(CH_QUOTE);
        send_byte(8'h00);
        send_eot();
        send_byte(CH_BSL);
        send_eot();
        send_byte(CH_BSL);
        send_byte(8'h01);
        send_unit(16'hDC00);
        send_byte(CH_BSL);
        send_byte(CH_U);
        send_byte(8'h67);
        send_unit(16'hD83D);
        send_byte(8'h78);

        while (requests_sent < DIRECTED_COUNT + RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_string();
        end
        push <= 1'b0;

        while (results_outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int gap;
        int pops;
        pops = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            draw_gap(recv_burst, gap);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            @(negedge clk);
            pops++;
            if (pops == HOLD_AFTER)
            begin
                reader_holding = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                reader_holding = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_fifo.sv
rtl/jsu_front.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
verif/json_string_unescape_utf8_checker.sv
verif/json_string_unescape_utf8_tb.sv
